### design/sicxe_instruction_step_unit_defines.svh
// ----------------------------------------------------------------------------
// sicxe_instruction_step_unit_defines
// Assertion macros shared by the step unit RTL.
// Each macro expects clk_i and rst_ni in the scope of use.
// ----------------------------------------------------------------------------
`ifndef SICXE_INSTRUCTION_STEP_UNIT_DEFINES_SVH
`define SICXE_INSTRUCTION_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset
`define SICXE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sicxe: same-cycle check failed");

// Next-cycle implication, off during reset
`define SICXE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sicxe: next-cycle check failed");

`endif

### design/sicxe_pkg.sv
// ----------------------------------------------------------------------------
// sicxe_pkg
// Types, codes and decode helpers shared by the SIC/XE step unit.
// ----------------------------------------------------------------------------
package sicxe_pkg;

  localparam int unsigned MEM_ADDR_BITS_DEF = 16;
  localparam int unsigned WORD_W = 24;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned PADDR_W = 25;

  localparam logic [ADDR_W-1:0] ADDR_TOP = 20'hFFFFF;

  // Command codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SETPC = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  // Condition codes
  localparam logic [1:0] CC_LESS    = 2'd0;
  localparam logic [1:0] CC_EQUAL   = 2'd1;
  localparam logic [1:0] CC_GREATER = 2'd2;
  localparam logic [1:0] CC_WSTUB   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_HALT  = 2'd2;
  localparam logic [1:0] ST_BREAK = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_END  = 2'd0;
  localparam logic [1:0] CFG_BP   = 2'd1;
  localparam logic [1:0] CFG_BPEN = 2'd2;

  // Register codes
  localparam logic [3:0] RC_A = 4'd0;
  localparam logic [3:0] RC_X = 4'd1;
  localparam logic [3:0] RC_L = 4'd2;
  localparam logic [3:0] RC_B = 4'd3;
  localparam logic [3:0] RC_S = 4'd4;
  localparam logic [3:0] RC_T = 4'd5;

  // Opcodes that do something
  localparam logic [7:0] OP_MASK  = 8'hFC;
  localparam logic [7:0] OP_LDA   = 8'h00;
  localparam logic [7:0] OP_LDB   = 8'h68;
  localparam logic [7:0] OP_LDT   = 8'h74;
  localparam logic [7:0] OP_LDX   = 8'h04;
  localparam logic [7:0] OP_LDCH  = 8'h50;
  localparam logic [7:0] OP_STA   = 8'h0C;
  localparam logic [7:0] OP_STL   = 8'h14;
  localparam logic [7:0] OP_STX   = 8'h10;
  localparam logic [7:0] OP_STCH  = 8'h54;
  localparam logic [7:0] OP_COMP  = 8'h28;
  localparam logic [7:0] OP_J     = 8'h3C;
  localparam logic [7:0] OP_JEQ   = 8'h30;
  localparam logic [7:0] OP_JLT   = 8'h38;
  localparam logic [7:0] OP_JSUB  = 8'h48;
  localparam logic [7:0] OP_RSUB  = 8'h4C;
  localparam logic [7:0] OP_TD    = 8'hE0;
  localparam logic [7:0] OP_WD    = 8'hDC;
  localparam logic [7:0] OP_CLEAR = 8'hB4;
  localparam logic [7:0] OP_COMPR = 8'hA0;
  localparam logic [7:0] OP_TIXR  = 8'hB8;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_TIX2,
    S_EA2,
    S_DISP,
    S_LDRQ,
    S_LDRD,
    S_APPLY,
    S_ST,
    S_DONE
  } state_e;

  // Request to the byte memory
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [PADDR_W-1:0] addr;
    logic [7:0]         wdata;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] l;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] pc;
    logic [1:0]        cc;
    logic [1:0]        status;
  } res_t;

  // Instruction format from the masked opcode; 0 means unknown
  function automatic logic [1:0] format_of(input logic [7:0] op);
    logic [1:0] f;
    unique case (op)
      8'hC4, 8'hC0, 8'hF4, 8'hC8, 8'hF0, 8'hF8: f = 2'd1;
      8'h90, 8'hB4, 8'hA0, 8'h9C, 8'h98, 8'hAC,
      8'hA4, 8'hA8, 8'h94, 8'hB0, 8'hB8: f = 2'd2;
      8'h18, 8'h58, 8'h40, 8'h28, 8'h88, 8'h24,
      8'h64, 8'h3C, 8'h30, 8'h34, 8'h38, 8'h48,
      8'h00, 8'h68, 8'h50, 8'h70, 8'h08, 8'h6C,
      8'h74, 8'h04, 8'hD0, 8'h20, 8'h60, 8'h44,
      8'hD8, 8'h4C, 8'hEC, 8'h0C, 8'h78, 8'h54,
      8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8, 8'h84,
      8'h10, 8'h1C, 8'h5C, 8'hE0, 8'h2C, 8'hDC: f = 2'd3;
      default: f = 2'd0;
    endcase
    return f;
  endfunction

  // Signed 24-bit compare into a condition code
  function automatic logic [1:0] compare_code(input logic [WORD_W-1:0] lhs,
                                              input logic [WORD_W-1:0] rhs);
    logic [1:0] c;
    if ($signed(lhs) > $signed(rhs)) begin
      c = CC_GREATER;
    end else if (lhs == rhs) begin
      c = CC_EQUAL;
    end else begin
      c = CC_LESS;
    end
    return c;
  endfunction

endpackage

### design/sicxe_mem.sv
// ----------------------------------------------------------------------------
// sicxe_mem
// Byte memory with one port, registered read and an address range filter:
// accesses above the top write nothing and read as zero.
// ----------------------------------------------------------------------------
module sicxe_mem #(
  parameter int unsigned MEM_ADDR_BITS = sicxe_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sicxe_pkg::mem_req_t req_i,
  output logic [7:0]          rdata_o,
  output logic                hit_o
);

  localparam int unsigned Depth = 1 << MEM_ADDR_BITS;

  logic [7:0]               mem_q [Depth];
  logic [7:0]               rdata_q;
  logic                     hit_q;
  logic                     in_range;
  logic [MEM_ADDR_BITS-1:0] idx;

  // Check the address against the top of memory
  assign in_range = (req_i.addr >> MEM_ADDR_BITS) == '0;
  assign idx      = req_i.addr[MEM_ADDR_BITS-1:0];

  // Write or read one byte
  always_ff @(posedge clk_i) begin
    if (req_i.wr && in_range) begin
      mem_q[idx] <= req_i.wdata;
    end else if (req_i.rd && in_range) begin
      rdata_q <= mem_q[idx];
    end
  end

  // Remember whether the last read hit memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (req_i.rd) begin
      hit_q <= in_range;
    end
  end

  assign hit_o   = hit_q;
  assign rdata_o = hit_q ? rdata_q : 8'h00;

endmodule

### design/sicxe_instruction_step_unit.sv
// ----------------------------------------------------------------------------
// sicxe_instruction_step_unit
// Runs a subset of the SIC/XE machine one command at a time.
// ----------------------------------------------------------------------------
// One command is taken at a time and the unit is not ready while it works.
// Write byte, set PC and reset registers go straight to the hand-over, as does
// a halted or stopped step. An executed step issues the first fetch, takes in
// each fetched byte (1 to 4) and hands over the result; format 2 adds an execute
// step (and a compare step for TIXR), format 3 adds operand address and
// dispatch steps, a request and a read per operand byte, an apply step per word
// read and a write per byte stored, all through the single memory port. A
// result waits in an output register until taken; the hand-over, and so the
// next command, waits while that register is still full.
module sicxe_instruction_step_unit #(
  parameter int unsigned MEM_ADDR_BITS = sicxe_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  // command items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [19:0] address_i,
  input  logic [7:0]  write_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] reg_a_o,
  output logic [23:0] reg_x_o,
  output logic [23:0] reg_l_o,
  output logic [23:0] reg_b_o,
  output logic [23:0] reg_s_o,
  output logic [23:0] reg_t_o,
  output logic [23:0] program_counter_o,
  output logic [1:0]  condition_o,
  output logic [1:0]  status_o
);

  `include "sicxe_instruction_step_unit_defines.svh"

  localparam int unsigned W = sicxe_pkg::WORD_W;

  sicxe_pkg::state_e   state_q, state_d;
  sicxe_pkg::mem_req_t mem_req;
  sicxe_pkg::res_t     res_q, res_d;

  logic [W-1:0] a_q, a_d, x_q, x_d, l_q, l_d, b_q, b_d, s_q, s_d, t_q, t_d;
  logic [W-1:0] pc_q, pc_d;
  logic [1:0]   cc_q, cc_d;
  logic         armed_q, armed_d;
  logic [19:0]  end_q, bp_q;
  logic         bpen_q;
  logic         out_valid_q, out_valid_d;
  logic [1:0]   status_q, status_d;

  logic [1:0]   fcnt_q, fcnt_d;
  logic [7:0]   b0_q, b0_d;
  logic [1:0]   fmt_q, fmt_d;
  logic [3:0]   xbpe_q, xbpe_d;
  logic [19:0]  data_q, data_d;
  logic [W-1:0] ea_q, ea_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] st_q, st_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         one_q, one_d;
  logic         ptr_q, ptr_d;

  logic [7:0]   rdata;
  logic         rhit;
  logic [W:0]   add_a, add_b, sum;
  logic [7:0]   op;
  logic [1:0]   ni;
  logic [3:0]   r1, r2;
  logic [W-1:0] disp_ext, r1_val, r2_val;
  logic         in_acc, last_byte, is_load, is_store, is_jump, jump_ok, is_byte_op;

  // Read a register by code; unused codes read as zero
  function automatic logic [W-1:0] sel_reg(input logic [3:0] code,
      input logic [W-1:0] ra, input logic [W-1:0] rx, input logic [W-1:0] rl,
      input logic [W-1:0] rb, input logic [W-1:0] rs, input logic [W-1:0] rt);
    logic [W-1:0] v;
    unique case (code)
      sicxe_pkg::RC_A: v = ra;
      sicxe_pkg::RC_X: v = rx;
      sicxe_pkg::RC_L: v = rl;
      sicxe_pkg::RC_B: v = rb;
      sicxe_pkg::RC_S: v = rs;
      sicxe_pkg::RC_T: v = rt;
      default:         v = '0;
    endcase
    return v;
  endfunction

  sicxe_mem #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata),
    .hit_o  (rhit)
  );

  // Configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q  <= sicxe_pkg::ADDR_TOP;
      bp_q   <= '0;
      bpen_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sicxe_pkg::CFG_END:  end_q  <= cfg_data_i;
        sicxe_pkg::CFG_BP:   bp_q   <= cfg_data_i;
        sicxe_pkg::CFG_BPEN: bpen_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Decode helpers
  assign op  = b0_q & sicxe_pkg::OP_MASK;
  assign ni  = b0_q[1:0];
  assign r1  = data_q[7:4];
  assign r2  = data_q[3:0];
  assign in_acc = in_valid_i && in_ready_o;
  assign r1_val = sel_reg(r1, a_q, x_q, l_q, b_q, s_q, t_q);
  assign r2_val = sel_reg(r2, a_q, x_q, l_q, b_q, s_q, t_q);
  assign last_byte = one_q ? (cnt_q == 2'd0) : (cnt_q == 2'd2);

  assign is_load = (op == sicxe_pkg::OP_LDA) || (op == sicxe_pkg::OP_LDB) ||
                   (op == sicxe_pkg::OP_LDT) || (op == sicxe_pkg::OP_LDX) ||
                   (op == sicxe_pkg::OP_LDCH) || (op == sicxe_pkg::OP_COMP);
  assign is_store = (op == sicxe_pkg::OP_STA) || (op == sicxe_pkg::OP_STL) ||
                    (op == sicxe_pkg::OP_STX) || (op == sicxe_pkg::OP_STCH);
  assign is_jump = (op == sicxe_pkg::OP_J) || (op == sicxe_pkg::OP_JEQ) ||
                   (op == sicxe_pkg::OP_JLT) || (op == sicxe_pkg::OP_JSUB);
  assign is_byte_op = (op == sicxe_pkg::OP_LDCH) || (op == sicxe_pkg::OP_STCH);
  assign jump_ok = !(((op == sicxe_pkg::OP_JEQ) && (cc_q != sicxe_pkg::CC_EQUAL)) ||
                     ((op == sicxe_pkg::OP_JLT) && (cc_q != sicxe_pkg::CC_LESS) &&
                      (cc_q != sicxe_pkg::CC_WSTUB)));

  // Sign-extend only a PC-relative format 3 displacement
  always_comb begin
    if (xbpe_q[0]) begin
      disp_ext = {4'h0, data_q};
    end else if (xbpe_q[1] && data_q[11]) begin
      disp_ext = {12'hFFF, data_q[11:0]};
    end else begin
      disp_ext = {12'h000, data_q[11:0]};
    end
  end

  // Shared adder operands
  always_comb begin
    add_a = {1'b0, pc_q};
    add_b = {{W{1'b0}}, 1'b1};
    unique case (state_q)
      sicxe_pkg::S_EXEC: begin
        if (fmt_q == 2'd2) begin
          add_a = {1'b0, x_q};
        end else begin
          add_a = {1'b0, disp_ext};
          add_b = xbpe_q[3] ? {1'b0, x_q} : '0;
        end
      end
      sicxe_pkg::S_EA2: begin
        add_a = {1'b0, ea_q};
        add_b = xbpe_q[1] ? {1'b0, pc_q} : (xbpe_q[2] ? {1'b0, b_q} : '0);
      end
      sicxe_pkg::S_LDRQ, sicxe_pkg::S_ST: begin
        add_a = {1'b0, base_q};
        add_b = {{(W-1){1'b0}}, cnt_q};
      end
      default: ;
    endcase
  end

  assign sum = add_a + add_b;

  // Jump target arming
  function automatic logic arm_for(input logic en, input logic [19:0] bp,
                                   input logic [W-1:0] target);
    return en && ({4'h0, bp} >= target);
  endfunction

  // Sequencer: next state, register updates and memory requests
  always_comb begin
    state_d = state_q;
    a_d = a_q; x_d = x_q; l_d = l_q; b_d = b_q; s_d = s_q; t_d = t_q;
    pc_d = pc_q; cc_d = cc_q; armed_d = armed_q;
    status_d = status_q;
    fcnt_d = fcnt_q; b0_d = b0_q; fmt_d = fmt_q; xbpe_d = xbpe_q; data_d = data_q;
    ea_d = ea_q; base_d = base_q; acc_d = acc_q; st_d = st_q;
    cnt_d = cnt_q; one_d = one_q; ptr_d = ptr_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req = '0;
    in_ready_o = (state_q == sicxe_pkg::S_IDLE);

    unique case (state_q)
      sicxe_pkg::S_IDLE: begin
        if (in_acc) begin
          status_d = sicxe_pkg::ST_DONE;
          state_d  = sicxe_pkg::S_DONE;
          unique case (sicxe_pkg::cmd_e'(opcode_i))
            sicxe_pkg::CMD_WRITE: begin
              mem_req.wr    = 1'b1;
              mem_req.addr  = {5'h00, address_i};
              mem_req.wdata = write_byte_i;
            end
            sicxe_pkg::CMD_SETPC: begin
              pc_d    = {4'h0, address_i};
              armed_d = arm_for(bpen_q, bp_q, {4'h0, address_i});
            end
            sicxe_pkg::CMD_STEP: begin
              if ((pc_q >= {4'h0, end_q}) || (pc_q > {4'h0, sicxe_pkg::ADDR_TOP})) begin
                status_d = sicxe_pkg::ST_HALT;
              end else if (armed_q && bpen_q && (pc_q >= {4'h0, bp_q})) begin
                status_d = sicxe_pkg::ST_BREAK;
              end else begin
                status_d     = sicxe_pkg::ST_EXEC;
                mem_req.rd   = 1'b1;
                mem_req.addr = {1'b0, pc_q};
                fcnt_d       = 2'd0;
                state_d      = sicxe_pkg::S_FETCH;
              end
            end
            sicxe_pkg::CMD_RESET: begin
              a_d = '0; x_d = '1; l_d = '1; b_d = '1; s_d = '0; t_d = '0;
              pc_d = '1; cc_d = sicxe_pkg::CC_EQUAL; armed_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      // Take in one instruction byte and ask for the next if needed
      sicxe_pkg::S_FETCH: begin
        pc_d         = sum[W-1:0];
        mem_req.addr = {1'b0, sum[W-1:0]};
        unique case (fcnt_q)
          2'd0: begin
            b0_d  = rdata;
            fmt_d = sicxe_pkg::format_of(rdata & sicxe_pkg::OP_MASK);
            if ((fmt_d == 2'd2) || ((fmt_d == 2'd3) && (rdata[1:0] != 2'b00))) begin
              mem_req.rd = 1'b1;
              fcnt_d     = 2'd1;
            end else begin
              state_d = sicxe_pkg::S_DONE;
            end
          end
          2'd1: begin
            if (fmt_q == 2'd2) begin
              data_d  = {12'h000, rdata};
              state_d = sicxe_pkg::S_EXEC;
            end else begin
              xbpe_d     = rdata[7:4];
              data_d     = {16'h0000, rdata[3:0]};
              mem_req.rd = 1'b1;
              fcnt_d     = 2'd2;
            end
          end
          2'd2: begin
            data_d = {data_q[11:0], rdata};
            if (xbpe_q[0]) begin
              mem_req.rd = 1'b1;
              fcnt_d     = 2'd3;
            end else begin
              state_d = sicxe_pkg::S_EXEC;
            end
          end
          default: begin
            data_d  = {data_q[11:0], rdata};
            state_d = sicxe_pkg::S_EXEC;
          end
        endcase
      end

      // Format 2 work, or first half of the operand address
      sicxe_pkg::S_EXEC: begin
        state_d = sicxe_pkg::S_DONE;
        if (fmt_q == 2'd2) begin
          priority if (op == sicxe_pkg::OP_CLEAR) begin
            unique case (r1)
              sicxe_pkg::RC_A: a_d = '0;
              sicxe_pkg::RC_X: x_d = '0;
              sicxe_pkg::RC_L: l_d = '0;
              sicxe_pkg::RC_B: b_d = '0;
              sicxe_pkg::RC_S: s_d = '0;
              sicxe_pkg::RC_T: t_d = '0;
              default: ;
            endcase
          end else if (op == sicxe_pkg::OP_COMPR) begin
            cc_d = sicxe_pkg::compare_code(r1_val, r2_val);
          end else if (op == sicxe_pkg::OP_TIXR) begin
            x_d     = sum[W-1:0];
            state_d = sicxe_pkg::S_TIX2;
          end else begin
          end
        end else begin
          ea_d    = sum[W-1:0];
          state_d = sicxe_pkg::S_EA2;
        end
      end

      // Compare the stepped X
      sicxe_pkg::S_TIX2: begin
        cc_d    = sicxe_pkg::compare_code(x_q, r1_val);
        state_d = sicxe_pkg::S_DONE;
      end

      // Add the PC or base
      sicxe_pkg::S_EA2: begin
        ea_d    = sum[W-1:0];
        state_d = sicxe_pkg::S_DISP;
      end

      // Pick the operand path for the opcode
      sicxe_pkg::S_DISP: begin
        state_d = sicxe_pkg::S_DONE;
        base_d  = ea_q;
        cnt_d   = 2'd0;
        acc_d   = '0;
        one_d   = 1'b0;
        ptr_d   = 1'b0;
        if (is_load) begin
          if (ni == 2'd1) begin
            acc_d   = ea_q;
            state_d = sicxe_pkg::S_APPLY;
          end else begin
            one_d   = (ni == 2'd3) && is_byte_op;
            ptr_d   = (ni == 2'd2);
            state_d = sicxe_pkg::S_LDRQ;
          end
        end else if (is_store) begin
          if (ni == 2'd3) begin
            one_d   = is_byte_op;
            state_d = sicxe_pkg::S_ST;
          end else if (ni == 2'd2) begin
            ptr_d   = 1'b1;
            state_d = sicxe_pkg::S_LDRQ;
          end
        end else if (is_jump) begin
          if (jump_ok) begin
            if (ni == 2'd2) begin
              state_d = sicxe_pkg::S_LDRQ;
            end else begin
              acc_d   = ea_q;
              state_d = sicxe_pkg::S_APPLY;
            end
          end
        end else if (op == sicxe_pkg::OP_RSUB) begin
          acc_d   = l_q;
          state_d = sicxe_pkg::S_APPLY;
        end else if (op == sicxe_pkg::OP_TD) begin
          cc_d = sicxe_pkg::CC_GREATER;
        end else if (op == sicxe_pkg::OP_WD) begin
          cc_d = sicxe_pkg::CC_WSTUB;
        end
        // Line up the store value, top byte first
        unique case (op)
          sicxe_pkg::OP_STL:  st_d = l_q;
          sicxe_pkg::OP_STX:  st_d = x_q;
          sicxe_pkg::OP_STCH: st_d = {a_q[7:0], 16'h0000};
          default:            st_d = a_q;
        endcase
      end

      // Ask for one operand byte
      sicxe_pkg::S_LDRQ: begin
        mem_req.rd   = 1'b1;
        mem_req.addr = sum;
        state_d      = sicxe_pkg::S_LDRD;
      end

      // Shift in the byte if it was within memory
      sicxe_pkg::S_LDRD: begin
        if (rhit) begin
          acc_d = {acc_q[15:0], rdata};
        end
        cnt_d   = cnt_q + 2'd1;
        state_d = last_byte ? sicxe_pkg::S_APPLY : sicxe_pkg::S_LDRQ;
      end

      // Follow a pointer, or finish a load or jump
      sicxe_pkg::S_APPLY: begin
        state_d = sicxe_pkg::S_DONE;
        if (ptr_q) begin
          ptr_d  = 1'b0;
          base_d = acc_q;
          cnt_d  = 2'd0;
          acc_d  = '0;
          one_d  = is_byte_op;
          state_d = is_store ? sicxe_pkg::S_ST : sicxe_pkg::S_LDRQ;
        end else begin
          priority if (is_jump || (op == sicxe_pkg::OP_RSUB)) begin
            if (op == sicxe_pkg::OP_JSUB) begin
              l_d = pc_q;
            end
            pc_d    = acc_q;
            armed_d = arm_for(bpen_q, bp_q, acc_q);
          end else if (op == sicxe_pkg::OP_LDA) begin
            a_d = acc_q;
          end else if (op == sicxe_pkg::OP_LDB) begin
            b_d = acc_q;
          end else if (op == sicxe_pkg::OP_LDT) begin
            t_d = acc_q;
          end else if (op == sicxe_pkg::OP_LDX) begin
            x_d = acc_q;
          end else if (op == sicxe_pkg::OP_LDCH) begin
            a_d = {a_q[W-1:8], acc_q[7:0]};
          end else if (op == sicxe_pkg::OP_COMP) begin
            cc_d = sicxe_pkg::compare_code(a_q, acc_q);
          end else begin
          end
        end
      end

      // Write one operand byte; the memory drops it above the top
      sicxe_pkg::S_ST: begin
        mem_req.wr    = 1'b1;
        mem_req.addr  = sum;
        mem_req.wdata = st_q[W-1:W-8];
        st_d          = {st_q[W-9:0], 8'h00};
        cnt_d         = cnt_q + 2'd1;
        state_d       = last_byte ? sicxe_pkg::S_DONE : sicxe_pkg::S_ST;
      end

      // Hand the result over once the output register has room
      sicxe_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_d = '{a: a_q, x: x_q, l: l_q, b: b_q, s: s_q, t: t_q,
                    pc: pc_q, cc: cc_q, status: status_q};
          out_valid_d = 1'b1;
          state_d     = sicxe_pkg::S_IDLE;
        end
      end

      default: state_d = sicxe_pkg::S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sicxe_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      a_q <= '0; x_q <= '1; l_q <= '1; b_q <= '1; s_q <= '0; t_q <= '0;
      pc_q    <= '1;
      cc_q    <= sicxe_pkg::CC_EQUAL;
      armed_q <= 1'b0;
      fcnt_q  <= '0;
      cnt_q   <= '0;
      ptr_q   <= 1'b0;
      one_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      a_q <= a_d; x_q <= x_d; l_q <= l_d; b_q <= b_d; s_q <= s_d; t_q <= t_d;
      pc_q    <= pc_d;
      cc_q    <= cc_d;
      armed_q <= armed_d;
      fcnt_q  <= fcnt_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      one_q   <= one_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    b0_q     <= b0_d;
    fmt_q    <= fmt_d;
    xbpe_q   <= xbpe_d;
    data_q   <= data_d;
    ea_q     <= ea_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    st_q     <= st_d;
    res_q    <= res_d;
  end

  assign out_valid_o       = out_valid_q;
  assign reg_a_o           = res_q.a;
  assign reg_x_o           = res_q.x;
  assign reg_l_o           = res_q.l;
  assign reg_b_o           = res_q.b;
  assign reg_s_o           = res_q.s;
  assign reg_t_o           = res_q.t;
  assign program_counter_o = res_q.pc;
  assign condition_o       = res_q.cc;
  assign status_o          = res_q.status;

  // Memory writes come only from a byte-write command or the store loop
  `SICXE_ASSERT_IMP(a_mem_wr_src, mem_req.wr, (state_q == sicxe_pkg::S_IDLE) || (state_q == sicxe_pkg::S_ST))
  // TIXR always goes on to its compare state
  `SICXE_ASSERT_NXT(a_tix_seq, (state_q == sicxe_pkg::S_EXEC) && (fmt_q == 2'd2) && (op == sicxe_pkg::OP_TIXR), state_q == sicxe_pkg::S_TIX2)
  // A new result only ever comes from the hand-over state
  `SICXE_ASSERT_IMP(a_out_src, out_valid_q && !$past(out_valid_q), $past(state_q) == sicxe_pkg::S_DONE)
  // The unit is not ready in the cycle after it accepts a command
  `SICXE_ASSERT_NXT(a_busy, in_valid_i && in_ready_o, !in_ready_o)

endmodule
